/* rtl/core/gf256_lagrange_secret_recover_assert.svh */
// Assertion macros shared by the secret recovery RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef GF256_LAGRANGE_SECRET_RECOVER_ASSERT_SVH
`define GF256_LAGRANGE_SECRET_RECOVER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising clock edge outside of reset.
`define GSLR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define GSLR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `GSLR_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define GSLR_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSLR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/gslr_pkg.sv */
// Shared types, field tables and GF(256) arithmetic for secret recovery.
// Depends on nothing; used by every module of the block.
package gslr_pkg;

  localparam int unsigned MAX_SHARES = 8;
  localparam int unsigned LANE_IDX_W = $clog2(MAX_SHARES);
  localparam int unsigned COUNT_W    = 4;

  localparam logic [8:0]  GF_ORDER = 9'd255;
  localparam logic [8:0]  GF_POLY  = 9'h11b;
  localparam logic [7:0]  GF_GEN   = 8'h03;

  typedef logic [255:0][7:0] gf_tab_t;

  typedef struct packed {
    logic [7:0] share_byte_7;
    logic [7:0] share_byte_6;
    logic [7:0] share_byte_5;
    logic [7:0] share_byte_4;
    logic [7:0] share_byte_3;
    logic [7:0] share_byte_2;
    logic [7:0] share_byte_1;
    logic [7:0] share_byte_0;
    logic       end_of_secret;
  } in_req_t;

  typedef struct packed {
    logic [7:0] recovered_byte;
    logic       end_of_secret_out;
    logic       bad_indexes;
  } out_req_t;

  // Settled per-configuration values handed from the register block to the lanes.
  typedef struct packed {
    logic [MAX_SHARES-1:0][7:0] weight;
    logic [MAX_SHARES-1:0]      lane_en;
    logic                       bad;
    logic                       busy;
  } cfg_state_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return r;
  endfunction

  // Powers of the generator; entry 255 wraps back to one.
  function automatic gf_tab_t gf_gen_exp();
    gf_tab_t    tab;
    logic [7:0] e;
    e = 8'h01;
    for (int k = 0; k < 255; k++) begin
      tab[k] = e;
      e = gf_mul(e, GF_GEN);
    end
    tab[255] = 8'h01;
    return tab;
  endfunction

  // Discrete log; the entry for zero is a don't-care and reads as zero.
  function automatic gf_tab_t gf_gen_log();
    gf_tab_t tab;
    gf_tab_t ex;
    ex  = gf_gen_exp();
    tab = '0;
    for (int k = 0; k < 255; k++) begin
      tab[ex[k]] = 8'(k);
    end
    tab[0] = 8'h00;
    return tab;
  endfunction

  localparam gf_tab_t GF_EXP = gf_gen_exp();
  localparam gf_tab_t GF_LOG = gf_gen_log();

endpackage

/* rtl/core/gslr_cfg.sv */
// Register file and Lagrange basis weight sequencer.
// Depends on gslr_pkg and the assertion macro header.
`include "gf256_lagrange_secret_recover_assert.svh"

module gslr_cfg
  import gslr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_state_t  cfg_o
);

  logic [COUNT_W-1:0]         count_q, count_d;
  logic [MAX_SHARES-1:0][7:0] x_q, x_d;
  logic                       busy_q, busy_d;
  logic [LANE_IDX_W-1:0]      i_q, i_d, j_q, j_d;
  logic [7:0]                 acc_q, acc_d;
  logic [MAX_SHARES-1:0][7:0] weight_q;
  logic                       bad_q, bad_d;
  logic [MAX_SHARES-1:0]      lane_en_q, lane_en_d;

  logic                       wr_en;
  logic [COUNT_W-1:0]         n_sat;
  logic [7:0]                 xi, xj, log_x, log_d;
  logic                       used;
  logic [8:0]                 sum1, sum2;
  logic [7:0]                 red1, red2;
  logic                       last_j;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = paddr[3] ? x_q : {{(64-COUNT_W){1'b0}}, count_q};

  assign n_sat = (count_q > COUNT_W'(MAX_SHARES)) ? COUNT_W'(MAX_SHARES) : count_q;

  always_comb begin
    count_d = count_q;
    x_d     = x_q;
    if (wr_en) begin
      if (paddr[3]) begin
        x_d = pwdata;
      end else begin
        count_d = pwdata[COUNT_W-1:0];
      end
    end
  end

  // Lane enables and index check: zero or repeated index among used lanes.
  always_comb begin
    bad_d     = 1'b0;
    lane_en_d = '0;
    for (int i = 0; i < MAX_SHARES; i++) begin
      lane_en_d[i] = (COUNT_W'(i) < n_sat);
      if (lane_en_d[i] && (x_q[i] == 8'h00)) begin
        bad_d = 1'b1;
      end
      for (int j = 0; j < i; j++) begin
        if (lane_en_d[i] && (x_q[i] == x_q[j])) begin
          bad_d = 1'b1;
        end
      end
    end
  end

  // One basis factor per cycle: acc += log(x_j) - log(x_j ^ x_i), mod 255.
  assign xi     = x_q[i_q];
  assign xj     = x_q[j_q];
  assign log_x  = GF_LOG[xj];
  assign log_d  = GF_LOG[xj ^ xi];
  assign used   = (j_q != i_q) && ({1'b0, j_q} < n_sat);
  assign sum1   = {1'b0, acc_q} + {1'b0, log_x};
  assign red1   = (sum1 >= GF_ORDER) ? 8'(sum1 - GF_ORDER) : sum1[7:0];
  assign sum2   = {1'b0, red1} + (GF_ORDER - {1'b0, log_d});
  assign red2   = (sum2 >= GF_ORDER) ? 8'(sum2 - GF_ORDER) : sum2[7:0];
  assign last_j = (j_q == LANE_IDX_W'(MAX_SHARES - 1));

  always_comb begin
    busy_d = busy_q;
    i_d    = i_q;
    j_d    = j_q;
    acc_d  = acc_q;
    if (wr_en) begin
      // Restart the sweep on any register write.
      busy_d = 1'b1;
      i_d    = '0;
      j_d    = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = used ? red2 : acc_q;
      j_d   = j_q + 1'b1;
      if (last_j) begin
        acc_d = '0;
        i_d   = i_q + 1'b1;
        if (i_q == LANE_IDX_W'(MAX_SHARES - 1)) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= COUNT_W'(1);
      x_q       <= 64'h0807060504030201;
      busy_q    <= 1'b1;
      i_q       <= '0;
      j_q       <= '0;
      acc_q     <= '0;
      bad_q     <= 1'b0;
      lane_en_q <= '0;
    end else begin
      count_q   <= count_d;
      x_q       <= x_d;
      busy_q    <= busy_d;
      i_q       <= i_d;
      j_q       <= j_d;
      acc_q     <= acc_d;
      bad_q     <= bad_d;
      lane_en_q <= lane_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !wr_en && last_j) begin
      weight_q[i_q] <= GF_EXP[used ? red2 : acc_q];
    end
  end

  assign cfg_o.weight  = weight_q;
  assign cfg_o.lane_en = lane_en_q;
  assign cfg_o.bad     = bad_q;
  assign cfg_o.busy    = busy_q;

  `GSLR_ASSERT(a_write_starts_sweep, clk_i, rst_ni, wr_en |=> (busy_q && (i_q == '0) && (j_q == '0)), "register write did not restart the weight sweep")
  `GSLR_ASSERT(a_sweep_ends_on_last, clk_i, rst_ni, $fell(busy_q) |-> ($past(i_q) == LANE_IDX_W'(MAX_SHARES - 1)), "weight sweep ended early")
  `GSLR_ASSERT_NEVER(a_acc_range, clk_i, rst_ni, {1'b0, acc_q} >= GF_ORDER, "log accumulator left mod-255 range")

endmodule

/* rtl/core/gslr_lane.sv */
// One share lane: weights a share byte by its basis value in GF(256).
// Depends on gslr_pkg.
module gslr_lane
  import gslr_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       en_i,
  input  logic [7:0] weight_i,
  input  logic [7:0] share_i,
  output logic [7:0] term_o
);

  logic [7:0] term_q, term_d;

  // Drop the contribution of lanes beyond the threshold.
  assign term_d = en_i ? gf_mul(weight_i, share_i) : 8'h00;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

/* rtl/core/gslr_merge.sv */
// Merging stage: XORs the lane terms and holds the result request.
// Depends on gslr_pkg and the assertion macro header.
`include "gf256_lagrange_secret_recover_assert.svh"

module gslr_merge
  import gslr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [MAX_SHARES-1:0][7:0] terms_i,
  input  logic                       eos_i,
  input  logic                       bad_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output out_req_t                   out_req_o
);

  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q, out_req_d;
  logic     load;
  logic [7:0] sum;

  always_comb begin
    sum = 8'h00;
    for (int i = 0; i < MAX_SHARES; i++) begin
      sum = sum ^ terms_i[i];
    end
  end

  assign ready_o = !out_valid_q || !out_stall_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    out_req_d.recovered_byte    = bad_i ? 8'h00 : sum;
    out_req_d.end_of_secret_out = eos_i;
    out_req_d.bad_indexes       = bad_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  `GSLR_ASSERT(a_bad_gives_zero, clk_i, rst_ni, (out_valid_q && out_req_q.bad_indexes) |-> (out_req_q.recovered_byte == 8'h00), "flagged result carries a nonzero byte")
  `GSLR_ASSERT(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q) |-> $past(valid_i), "result appeared without a lane stage entry")

endmodule

/* rtl/core/gf256_lagrange_secret_recover.sv */
// GF(256) Shamir secret recovery: one secret byte per request, by Lagrange
// interpolation at x = 0 over the 0x11b field. Each input request carries
// the share bytes of eight lanes at one byte position plus an end-of-secret
// mark; the result carries the recovered byte, the mark unchanged, and a flag
// that is set (with the byte forced to zero) when a used lane's x index is
// zero or repeats among the used lanes. Register 0 (byte address 0) holds the
// threshold; values above eight act as eight and zero gives a zero byte.
// Register 1 (byte address 8) holds the eight packed x indexes, lane 0 in the
// low byte. The basis weights depend only on these registers, so a weight
// sequencer works them out once, one basis factor per cycle as a mod-255 sum
// of table logs, after reset and after every register write, with the input
// stalled meanwhile. After that the block takes one request every clock while
// the output is not stalled: eight lanes each multiply their share byte by a
// stored weight into a lane register, and a merging stage XORs the lanes into
// the output register. An accepted request passes the lane registers and
// then the output register; a stalled result does not block the lane stage
// from taking one more request. Registers are to be written by the user only
// while no request is in flight; the block itself does not enforce this.
`include "gf256_lagrange_secret_recover_assert.svh"

module gf256_lagrange_secret_recover
  import gslr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Share requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  // Result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_req_t    out_req_o,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_state_t                 cfg;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_eos_q;
  logic                       s1_ready, s2_ready;
  logic                       in_accept;
  logic [MAX_SHARES-1:0][7:0] shares;
  logic [MAX_SHARES-1:0][7:0] terms;

  gslr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Hold input while weights settle or the lane stage cannot drain.
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = cfg.busy || !s1_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign shares[0] = in_req_i.share_byte_0;
  assign shares[1] = in_req_i.share_byte_1;
  assign shares[2] = in_req_i.share_byte_2;
  assign shares[3] = in_req_i.share_byte_3;
  assign shares[4] = in_req_i.share_byte_4;
  assign shares[5] = in_req_i.share_byte_5;
  assign shares[6] = in_req_i.share_byte_6;
  assign shares[7] = in_req_i.share_byte_7;

  for (genvar g = 0; g < MAX_SHARES; g++) begin : g_lane
    gslr_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (in_accept),
      .en_i     (cfg.lane_en[g]),
      .weight_i (cfg.weight[g]),
      .share_i  (shares[g]),
      .term_o   (terms[g])
    );
  end

  // Lane stage bookkeeping: advance on accept, drop once merged.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s2_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_eos_q <= in_req_i.end_of_secret;
    end
  end

  gslr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid_q),
    .terms_i     (terms),
    .eos_i       (s1_eos_q),
    .bad_i       (cfg.bad),
    .ready_o     (s2_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  `GSLR_ASSERT_NEVER(a_no_sweep_in_flight, clk_i, rst_ni, (s1_valid_q || out_valid_o) && cfg.busy, "weight sweep ran with requests in flight")

endmodule
